/* rtl/spq_pkg.sv */
package spq_pkg;

    // Command codes carried on the command field.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Highest priority value that an enqueue may carry.
    localparam logic [2:0] MAX_PRIORITY = 3'd5;

    // Data word returned whenever no entry is removed.
    localparam logic signed [31:0] NONE_VALUE = -32'sd1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADPRIO = 2'd3
    } t_status;

    // One queue entry: data word and priority.
    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         prio;
    } t_entry;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic   ins;
        logic   del;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

/* rtl/stable_priority_queue_unit.sv */
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+---------------------------------------
// input     | in        | i_valid / o_stall   | i_command, i_item_value, i_item_priority
// result    | out       | o_valid / i_stall   | o_status, o_out_value, o_fill_level
//
// Each transaction is decoded and applied to the row of cells in the cycle it is
// accepted; its result appears in the output register on the next cycle.
// One transaction per cycle is sustained while the result side keeps up; every
// cell compares and shifts in parallel, so depth does not change the rate.
// o_stall rises only when a result is held and the result side is stalling.
// Reset clears the entry count and the output valid; cell contents are not reset.
module stable_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_item_value,
    input  logic [2:0]         i_item_priority,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_value,
    output logic [4:0]         o_fill_level
);
    import spq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic signed [31:0] r_out_value;
    logic signed [31:0] n_out_value;
    logic [4:0]         r_fill;
    logic [4:0]         n_fill;

    logic       w_accept;
    logic       w_enq;
    logic       w_bad;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;
    t_entry     w_entry [QUEUE_DEPTH];
    logic       w_le    [QUEUE_DEPTH];

    // Transaction decode.
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_enq    = (i_command == CMD_ENQUEUE);
    assign w_bad    = (i_item_priority > MAX_PRIORITY);
    assign w_full   = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctrl.ins             = w_accept && w_enq && !w_bad && !w_full;
    assign w_ctrl.del             = w_accept && !w_enq && !w_empty;
    assign w_ctrl.new_entry.value = i_item_value;
    assign w_ctrl.new_entry.prio  = i_item_priority;

    // Row of cells, each linked to both neighbours.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic   w_left_le;
        t_entry w_left_entry;
        t_entry w_right_entry;

        // The first cell has an empty prefix to its left, so it takes the new
        // entry whenever it does not stay put itself.
        if (g == 0) begin : g_first
            assign w_left_le    = 1'b1;
            assign w_left_entry = w_entry[g];
        end else begin : g_mid
            assign w_left_le    = w_le[g-1];
            assign w_left_entry = w_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right_entry = w_entry[g];
        end else begin : g_inner
            assign w_right_entry = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occ         (CW'(g) < r_count),
            .i_left_le     (w_left_le),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .o_entry       (w_entry[g]),
            .o_le          (w_le[g])
        );
    end

    // Result and count update.
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_out_value = r_out_value;
        n_fill      = r_fill;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_value = NONE_VALUE;
            if (w_enq) begin
                if (w_bad) begin
                    n_status = ST_BADPRIO;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count + CW'(1);
                end
            end else if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status    = ST_OK;
                n_out_value = w_entry[0].value;
                n_count     = r_count - CW'(1);
            end
            n_fill = 5'(n_count);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_out_value <= n_out_value;
        r_fill      <= n_fill;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_out_value  = r_out_value;
    assign o_fill_level = r_fill;

endmodule

/* rtl/spq_cell.sv */
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occ,
    input  logic                i_left_le,
    input  spq_pkg::t_entry     i_left_entry,
    input  spq_pkg::t_entry     i_right_entry,
    output spq_pkg::t_entry     o_entry,
    output logic                o_le
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // This cell stays put on insertion when it holds an entry that the new one
    // must queue behind. Being a sorted row, these cells form a prefix.
    assign o_le    = i_occ && (r_entry.prio <= i_ctrl.new_entry.prio);
    assign o_entry = r_entry;

    // On insertion the first cell past the prefix takes the new entry and the
    // cells after it take their left neighbour; on removal every cell but the
    // last takes its right neighbour, and the last cell keeps its own entry.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (!o_le) begin
                if (i_left_le) begin
                    n_entry = i_ctrl.new_entry;
                end else begin
                    n_entry = i_left_entry;
                end
            end
        end else if (i_ctrl.del) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* rtl/spq_checker.sv */
module spq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_out_value,
    input logic [4:0]         o_fill_level
);
    import spq_pkg::*;

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_value)
            && $stable(o_fill_level))
        else $error("stalled result changed");

    // An accepted transaction always yields a result on the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted transaction gave no result");

    // Only a successful dequeue returns a data word.
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_out_value == NONE_VALUE)
        else $error("refused transaction returned data");

    // An empty status means the queue holds nothing.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_fill_level == 5'd0)
        else $error("empty status with entries held");

    // A full status means the queue holds its whole depth.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_fill_level == 5'(QUEUE_DEPTH))
        else $error("full status below depth");

endmodule

bind stable_priority_queue_unit spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);
